// ===== design/nmea_gll_field_capture_assert.svh =====
// Assertion helpers for the GLL field capture block.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef NMEA_GLL_FIELD_CAPTURE_ASSERT_SVH
`define NMEA_GLL_FIELD_CAPTURE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGLL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NGLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ngll_pkg.sv =====
`default_nettype none

package ngll_pkg;

    // Capture sizing
    localparam int CAPTURE_LIMIT = 32;
    localparam int POS_W         = 6;
    localparam int COMMA_W       = 3;
    localparam int HDR_W         = 48;

    // Register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic REG_HEADER_PATTERN = 1'b0;

    // Default header "$GNGLL", first character in the top byte
    localparam logic [HDR_W-1:0] HEADER_RESET = 48'h2447_4E47_4C4C;

    // Characters of interest
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_STATUS_OK = 8'h41;

    // Commas that close the position fields
    localparam logic [COMMA_W-1:0] FIELD_COMMAS = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SEP       = 3'd1,
        PH_CAPTURE   = 3'd2,
        PH_SKIP_TIME = 3'd3,
        PH_STATUS    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_BYTE    = 2'd0,
        EV_ACCEPT  = 2'd1,
        EV_REJECT  = 2'd2,
        EV_ABANDON = 2'd3
    } event_kind_t;

endpackage

`default_nettype wire

// ===== design/nmea_gll_field_capture.sv =====
// GLL position field capture.
// s_tdata carries one received character per transaction. The block keeps
// the last six characters and restarts a capture whenever they equal the
// header held in the header_pattern register (APB, byte address 0, bits
// 47..0). After the comma that follows the header, every latitude and
// longitude character up to and including the fourth comma leaves on the
// master side as a field-byte event, tagged with its field index. The time
// field is skipped, and the status character then gives an accepted or a
// rejected event. A missing comma after the header or a too-long capture
// gives an abandoned event.
// A result is on m_tdata/m_tuser in the cycle after the character that
// causes it is taken. One character per cycle unless stalled; all the
// work is a single pass from the state registers into the output register.
// When the receiver stalls, the output register holds its transaction and
// s_tready stays high only while that register is empty or being emptied.
// Reset clears the window to zeros, the parser to waiting for a header,
// the output register to empty and the header register to "$GNGLL".
`default_nettype none

module nmea_gll_field_capture
    import ngll_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // Received characters
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // [7:0] rx_byte

    // Capture events
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,    // [7:0] field_byte, [9:8] field_index
    output logic [1:0]              m_tuser,    // [1:0] event_kind

    // Configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [HDR_W-1:0]   header_reg;
    logic [HDR_W-1:0]   window_reg;
    logic [HDR_W-1:0]   window_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COMMA_W-1:0] comma_reg;
    logic [COMMA_W-1:0] comma_next;
    logic [COMMA_W-1:0] comma_after;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   pos_inc;
    logic               is_comma;
    logic               hdr_match;
    logic               overflow;
    logic               accept;

    logic               res_valid;
    event_kind_t        res_kind;
    logic [7:0]         res_byte;
    logic [1:0]         res_index;

    logic               m_valid_reg;
    event_kind_t        kind_reg;
    logic [7:0]         byte_reg;
    logic [1:0]         index_reg;

    // Configuration port: one 48-bit register, writes complete in the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[3] == REG_HEADER_PATTERN))
        begin
            header_reg <= pwdata[HDR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[3] == REG_HEADER_PATTERN)
        begin
            prdata = {{(PDATA_W-HDR_W){1'b0}}, header_reg};
        end
    end

    // Input handshake: take a character whenever the output register can take its result.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sliding window and per-character decodes.
    assign window_next = {window_reg[HDR_W-9:0], s_tdata};
    assign hdr_match   = (window_next == header_reg);
    assign is_comma    = (s_tdata == CHAR_COMMA);
    assign pos_inc     = pos_reg + POS_W'(1);
    assign overflow    = (pos_inc >= POS_W'(CAPTURE_LIMIT));
    assign comma_after = is_comma ? (comma_reg + COMMA_W'(1)) : comma_reg;

    // Next parser state. A header match overrides the current phase.
    always_comb
    begin
        phase_next = phase_reg;
        comma_next = comma_reg;
        pos_next   = pos_reg;
        if (hdr_match)
        begin
            phase_next = PH_SEP;
            comma_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SEP:
                begin
                    if (is_comma)
                    begin
                        phase_next = PH_CAPTURE;
                        comma_next = '0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_CAPTURE:
                begin
                    pos_next = pos_inc;
                    if (overflow)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        comma_next = comma_after;
                        if (comma_after == FIELD_COMMAS)
                        begin
                            phase_next = PH_SKIP_TIME;
                        end
                    end
                end
                PH_SKIP_TIME:
                begin
                    if (is_comma)
                    begin
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result of the current character, if any.
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = EV_BYTE;
        res_byte  = '0;
        res_index = '0;
        if (!hdr_match)
        begin
            unique case (phase_reg)
                PH_SEP:
                begin
                    if (!is_comma)
                    begin
                        res_valid = 1'b1;
                        res_kind  = EV_ABANDON;
                    end
                end
                PH_CAPTURE:
                begin
                    res_valid = 1'b1;
                    if (overflow)
                    begin
                        res_kind = EV_ABANDON;
                    end
                    else
                    begin
                        res_kind  = EV_BYTE;
                        res_byte  = s_tdata;
                        res_index = comma_reg[1:0];
                    end
                end
                PH_STATUS:
                begin
                    res_valid = 1'b1;
                    res_kind  = (s_tdata == CHAR_STATUS_OK) ? EV_ACCEPT : EV_REJECT;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Parser state registers advance once per accepted character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            phase_reg  <= PH_IDLE;
            comma_reg  <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            phase_reg  <= phase_next;
            comma_reg  <= comma_next;
            pos_reg    <= pos_next;
        end
    end

    // Output register: loaded on a result, emptied when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg  <= res_kind;
            byte_reg  <= res_byte;
            index_reg <= res_index;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'b0, index_reg, byte_reg};

    // Checks on the parser and the output register.
`include "nmea_gll_field_capture_assert.svh"

    `NGLL_ASSERT_SAME(a_event_payload_zero, m_tvalid && (kind_reg != EV_BYTE), m_tdata == 16'h0000, "non-byte event carries a nonzero payload")
    `NGLL_ASSERT_SAME(a_stall_only_when_full, !s_tready, m_valid_reg && !m_tready, "input stalled while the output register could take a result")
    `NGLL_ASSERT_SAME(a_capture_bounds, phase_reg == PH_CAPTURE, (comma_reg < FIELD_COMMAS) && (pos_reg < POS_W'(CAPTURE_LIMIT)), "capture state out of range")
    `NGLL_ASSERT_SAME(a_tail_commas, (phase_reg == PH_SKIP_TIME) || (phase_reg == PH_STATUS), comma_reg == FIELD_COMMAS, "time or status phase entered without four commas")
    `NGLL_ASSERT_NEXT(a_no_result_without_item, !accept && !m_valid_reg, !m_valid_reg, "result appeared with no character taken")

endmodule

`default_nettype wire
